### sv/bsc_pkg.sv
package bsc_pkg;

   localparam int DEF_MAX_PROCESSES = 16;
   localparam int DEF_MAX_RESOURCES = 8;
   localparam int QUEUE_DEPTH       = 2;

   localparam int OP_W     = 2;
   localparam int PID_W    = 4;
   localparam int RID_W    = 3;
   localparam int UNITS_W  = 15;
   localparam int AVAIL_W  = 17;
   localparam int COUNT_W  = 5;
   localparam int NRES_W   = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_PROCESSES = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_RESOURCES = 1'b1;

   localparam logic [COUNT_W-1:0] NUM_PROCESSES_RESET = 5'd4;
   localparam logic [NRES_W-1:0]  NUM_RESOURCES_RESET = 4'd3;

   localparam logic KIND_SEQUENCED = 1'b0;
   localparam logic KIND_SUMMARY   = 1'b1;

   localparam logic signed [AVAIL_W:0] AVAIL_MAX = 18'sd65535;
   localparam logic signed [AVAIL_W:0] AVAIL_MIN = -18'sd65536;

   typedef enum logic [OP_W-1:0] {
      OP_TOTAL = 2'd0,
      OP_ENTRY = 2'd1,
      OP_RUN   = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [PID_W-1:0]     pid;
      logic [RID_W-1:0]     rid;
      logic [UNITS_W-1:0]   total;
      logic [UNITS_W-1:0]   claim;
      logic [UNITS_W-1:0]   alloc;
   } cmd_type;

   typedef struct packed {
      logic                 kind;
      logic [PID_W-1:0]     pid;
      logic                 deadlock;
      logic [COUNT_W-1:0]   count;
      logic                 last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROC,
      ST_CHK_RD,
      ST_CHK_CMP,
      ST_RET_RD,
      ST_RET_WR,
      ST_EMIT,
      ST_SUMMARY
   } state_type;

   function automatic logic signed [AVAIL_W-1:0] sat17(input logic signed [AVAIL_W:0] v);
      logic signed [AVAIL_W-1:0] r;
      if (v > AVAIL_MAX) begin
         r = AVAIL_MAX[AVAIL_W-1:0];
      end else if (v < AVAIL_MIN) begin
         r = AVAIL_MIN[AVAIL_W-1:0];
      end else begin
         r = v[AVAIL_W-1:0];
      end
      return r;
   endfunction

endpackage

### sv/bsc_fifo.sv
module bsc_fifo #(
   parameter int  DEPTH = bsc_pkg::QUEUE_DEPTH,
   parameter type item_type = bsc_pkg::cmd_type
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output item_type pop_data,
   output logic     empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/bsc_front.sv
module bsc_front #(
   parameter int MAX_PROCESSES = bsc_pkg::DEF_MAX_PROCESSES,
   parameter int MAX_RESOURCES = bsc_pkg::DEF_MAX_RESOURCES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [bsc_pkg::OP_W-1:0]        req_operation,
   input  logic [bsc_pkg::PID_W-1:0]       req_process_index,
   input  logic [bsc_pkg::RID_W-1:0]       req_resource_index,
   input  logic [bsc_pkg::UNITS_W-1:0]     req_total_units,
   input  logic [bsc_pkg::UNITS_W-1:0]     req_max_claim,
   input  logic [bsc_pkg::UNITS_W-1:0]     req_allocated_units,
   output logic                            cmd_valid,
   output bsc_pkg::cmd_type                cmd,
   input  logic                            cmd_pop
);
   import bsc_pkg::*;

   cmd_type item;
   logic    keep;
   logic    rid_ok;
   logic    pid_ok;
   logic    cmd_empty;

   assign rid_ok = (int'(req_resource_index) < MAX_RESOURCES);
   assign pid_ok = (int'(req_process_index) < MAX_PROCESSES);

   always_comb begin
      item.op    = op_type'(req_operation);
      item.pid   = req_process_index;
      item.rid   = req_resource_index;
      item.total = req_total_units;
      item.claim = req_max_claim;
      item.alloc = req_allocated_units;
      unique case (item.op)
         OP_TOTAL: keep = rid_ok;
         OP_ENTRY: keep = rid_ok && pid_ok;
         OP_RUN:   keep = 1'b1;
         default:  keep = 1'b0;
      endcase
   end

   bsc_fifo #(
      .DEPTH     (QUEUE_DEPTH),
      .item_type (cmd_type)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push && keep),
      .push_data (item),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (cmd),
      .empty     (cmd_empty)
   );

   assign cmd_valid = !cmd_empty;

endmodule

### sv/bsc_engine.sv
module bsc_engine #(
   parameter int MAX_PROCESSES = bsc_pkg::DEF_MAX_PROCESSES,
   parameter int MAX_RESOURCES = bsc_pkg::DEF_MAX_RESOURCES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [bsc_pkg::COUNT_W-1:0]    num_processes,
   input  logic [bsc_pkg::NRES_W-1:0]     num_resources,
   input  logic                           cmd_valid,
   input  bsc_pkg::cmd_type               cmd,
   output logic                           cmd_pop,
   output logic                           rsp_push,
   output bsc_pkg::rsp_type               rsp,
   input  logic                           rsp_full
);
   import bsc_pkg::*;

   localparam int PCW   = $clog2(MAX_PROCESSES + 1);
   localparam int PIW   = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int RCW   = $clog2(MAX_RESOURCES + 1);
   localparam int RIW   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
   localparam int CELLS = MAX_PROCESSES * MAX_RESOURCES;
   localparam int CAW   = (CELLS > 1) ? $clog2(CELLS) : 1;

   state_type                   state_ff, state_in;
   logic [PCW-1:0]              i_ff, i_in;
   logic [RCW-1:0]              j_ff, j_in;
   logic [COUNT_W-1:0]          done_ff, done_in;
   logic                        prog_ff, prog_in;
   logic [MAX_PROCESSES-1:0]    seq_ff, seq_in;

   logic signed [AVAIL_W-1:0]   avail_ff [MAX_RESOURCES];
   logic signed [AVAIL_W-1:0]   need_mem_ff [CELLS];
   logic [UNITS_W-1:0]          held_mem_ff [CELLS];
   logic signed [AVAIL_W-1:0]   need_rd_ff;
   logic [UNITS_W-1:0]          held_rd_ff;

   logic [COUNT_W-1:0]          np;
   logic [RCW-1:0]              nr;
   logic [PIW-1:0]              i_idx;
   logic [RIW-1:0]              j_idx;
   logic [CAW-1:0]              run_cell;
   logic [CAW-1:0]              load_cell;
   logic [CAW-1:0]              wr_cell;
   logic [RIW-1:0]              av_idx;
   logic signed [AVAIL_W-1:0]   av_rd;
   logic                        av_we;
   logic signed [AVAIL_W-1:0]   av_wdata;
   logic                        tab_we;
   logic signed [AVAIL_W-1:0]   need_wdata;
   logic [UNITS_W-1:0]          held_wdata;
   logic signed [AVAIL_W-1:0]   need_load;

   assign np = (int'(num_processes) > MAX_PROCESSES) ? COUNT_W'(MAX_PROCESSES) : num_processes;
   assign nr = (int'(num_resources) > MAX_RESOURCES) ? RCW'(MAX_RESOURCES)
                                                     : RCW'(num_resources);

   assign i_idx     = i_ff[PIW-1:0];
   assign j_idx     = j_ff[RIW-1:0];
   assign run_cell  = CAW'(int'(i_idx) * MAX_RESOURCES + int'(j_idx));
   assign load_cell = CAW'(int'(cmd.pid) * MAX_RESOURCES + int'(cmd.rid));
   assign need_load = $signed({2'b00, cmd.claim}) - $signed({2'b00, cmd.alloc});
   assign av_rd     = avail_ff[av_idx];

   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      done_in    = done_ff;
      prog_in    = prog_ff;
      seq_in     = seq_ff;
      cmd_pop    = 1'b0;
      rsp_push   = 1'b0;
      rsp        = '0;
      av_idx     = j_idx;
      av_we      = 1'b0;
      av_wdata   = av_rd;
      tab_we     = 1'b0;
      wr_cell    = run_cell;
      need_wdata = need_load;
      held_wdata = '0;

      unique case (state_ff)
         ST_IDLE: begin
            av_idx = RIW'(cmd.rid);
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd.op)
                  OP_TOTAL: begin
                     av_we    = 1'b1;
                     av_wdata = $signed({2'b00, cmd.total});
                  end
                  OP_ENTRY: begin
                     av_we      = 1'b1;
                     av_wdata   = sat17($signed({av_rd[AVAIL_W-1], av_rd})
                                        - $signed({3'b000, cmd.alloc}));
                     tab_we     = 1'b1;
                     wr_cell    = load_cell;
                     held_wdata = cmd.alloc;
                  end
                  OP_RUN: begin
                     seq_in   = '0;
                     i_in     = '0;
                     j_in     = '0;
                     done_in  = '0;
                     prog_in  = 1'b0;
                     state_in = ST_PROC;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_PROC: begin
            j_in = '0;
            if (done_ff == np) begin
               state_in = ST_SUMMARY;
            end else if (i_ff >= PCW'(np)) begin
               if (prog_ff) begin
                  i_in    = '0;
                  prog_in = 1'b0;
               end else begin
                  state_in = ST_SUMMARY;
               end
            end else if (seq_ff[i_idx]) begin
               i_in = PCW'(i_ff + 1'b1);
            end else if (nr == '0) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_CHK_RD;
            end
         end

         ST_CHK_RD: begin
            state_in = ST_CHK_CMP;
         end

         ST_CHK_CMP: begin
            if (need_rd_ff > av_rd) begin
               i_in     = PCW'(i_ff + 1'b1);
               state_in = ST_PROC;
            end else if (RCW'(j_ff + 1'b1) == nr) begin
               j_in     = '0;
               state_in = ST_RET_RD;
            end else begin
               j_in     = RCW'(j_ff + 1'b1);
               state_in = ST_CHK_RD;
            end
         end

         ST_RET_RD: begin
            state_in = ST_RET_WR;
         end

         ST_RET_WR: begin
            av_we    = 1'b1;
            av_wdata = sat17($signed({av_rd[AVAIL_W-1], av_rd})
                             + $signed({3'b000, held_rd_ff}));
            tab_we     = 1'b1;
            need_wdata = need_rd_ff;
            if (RCW'(j_ff + 1'b1) == nr) begin
               state_in = ST_EMIT;
            end else begin
               j_in     = RCW'(j_ff + 1'b1);
               state_in = ST_RET_RD;
            end
         end

         ST_EMIT: begin
            if (!rsp_full) begin
               rsp_push       = 1'b1;
               rsp.kind       = KIND_SEQUENCED;
               rsp.pid        = PID_W'(i_ff);
               rsp.count      = COUNT_W'(done_ff + 1'b1);
               seq_in[i_idx]  = 1'b1;
               done_in        = COUNT_W'(done_ff + 1'b1);
               prog_in        = 1'b1;
               i_in           = PCW'(i_ff + 1'b1);
               state_in       = ST_PROC;
            end
         end

         ST_SUMMARY: begin
            if (!rsp_full) begin
               rsp_push     = 1'b1;
               rsp.kind     = KIND_SUMMARY;
               rsp.deadlock = (done_ff < np);
               rsp.count    = done_ff;
               rsp.last     = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         done_ff  <= '0;
         prog_ff  <= 1'b0;
         seq_ff   <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         done_ff  <= done_in;
         prog_ff  <= prog_in;
         seq_ff   <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_RESOURCES; k++) begin
            avail_ff[k] <= '0;
         end
      end else if (av_we) begin
         avail_ff[av_idx] <= av_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (tab_we) begin
         need_mem_ff[wr_cell] <= need_wdata;
         held_mem_ff[wr_cell] <= held_wdata;
      end
      need_rd_ff <= need_mem_ff[run_cell];
      held_rd_ff <= held_mem_ff[run_cell];
   end

endmodule

### sv/bankers_safety_check.sv
// Channel   Ports                                   Transfer when
// request   req_push, req_full, req_<field>         req_push && !req_full
// response  rsp_pop, rsp_empty, rsp_<field>         rsp_pop && !rsp_empty
// config    csr_wr_en, csr_index, csr_wr_data       csr_wr_en
//
// A load is handled in the engine's idle state; requests queue two deep ahead of the engine.
// A run visits each process in turn; for one not yet sequenced it compares
// resources until one fails (need-table read, compare), and for a process
// sequenced it returns each resource (held-table read, then add and zero) and
// emits a result, over as many passes as needed.
// Reset clears queues, state and available counts; the tables stay unwritten.
// A full response queue holds the engine; the request queue fills behind it.
module bankers_safety_check #(
   parameter int MAX_PROCESSES = bsc_pkg::DEF_MAX_PROCESSES,
   parameter int MAX_RESOURCES = bsc_pkg::DEF_MAX_RESOURCES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [bsc_pkg::OP_W-1:0]         req_operation,
   input  logic [bsc_pkg::PID_W-1:0]        req_process_index,
   input  logic [bsc_pkg::RID_W-1:0]        req_resource_index,
   input  logic [bsc_pkg::UNITS_W-1:0]      req_total_units,
   input  logic [bsc_pkg::UNITS_W-1:0]      req_max_claim,
   input  logic [bsc_pkg::UNITS_W-1:0]      req_allocated_units,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic                             rsp_result_kind,
   output logic [bsc_pkg::PID_W-1:0]        rsp_process_id,
   output logic                             rsp_deadlock,
   output logic [bsc_pkg::COUNT_W-1:0]      rsp_sequenced_count,
   output logic                             rsp_last,
   input  logic                             csr_wr_en,
   input  logic [bsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bsc_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import bsc_pkg::*;

   logic [COUNT_W-1:0] num_processes_ff, num_processes_in;
   logic [NRES_W-1:0]  num_resources_ff, num_resources_in;

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;
   logic    rsp_push;
   rsp_type rsp_in;
   rsp_type rsp_head;
   logic    rsp_full;

   always_comb begin
      num_processes_in = num_processes_ff;
      num_resources_in = num_resources_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_NUM_PROCESSES: num_processes_in = csr_wr_data[COUNT_W-1:0];
            CSR_NUM_RESOURCES: num_resources_in = csr_wr_data[NRES_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_processes_ff <= NUM_PROCESSES_RESET;
         num_resources_ff <= NUM_RESOURCES_RESET;
      end else begin
         num_processes_ff <= num_processes_in;
         num_resources_ff <= num_resources_in;
      end
   end

   bsc_front #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .MAX_RESOURCES (MAX_RESOURCES)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_operation       (req_operation),
      .req_process_index   (req_process_index),
      .req_resource_index  (req_resource_index),
      .req_total_units     (req_total_units),
      .req_max_claim       (req_max_claim),
      .req_allocated_units (req_allocated_units),
      .cmd_valid           (cmd_valid),
      .cmd                 (cmd),
      .cmd_pop             (cmd_pop)
   );

   bsc_engine #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .MAX_RESOURCES (MAX_RESOURCES)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .num_processes (num_processes_ff),
      .num_resources (num_resources_ff),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop),
      .rsp_push      (rsp_push),
      .rsp           (rsp_in),
      .rsp_full      (rsp_full)
   );

   bsc_fifo #(
      .DEPTH     (QUEUE_DEPTH),
      .item_type (rsp_type)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head),
      .empty     (rsp_empty)
   );

   assign rsp_result_kind     = rsp_head.kind;
   assign rsp_process_id      = rsp_head.pid;
   assign rsp_deadlock        = rsp_head.deadlock;
   assign rsp_sequenced_count = rsp_head.count;
   assign rsp_last            = rsp_head.last;

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("response pushed into a full queue");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("response queue not empty after reset");

   a_last_is_summary: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_last == rsp_result_kind))
      else $error("last flag and result kind disagree");

   a_deadlock_on_summary: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_deadlock) |-> rsp_last)
      else $error("deadlock flag on a sequenced result");

endmodule
